### sv/ecbt_pkg.sv
package ecbt_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam logic [31:0] OPEN_RET_BASE  = 32'hF100_0000;
  localparam logic [31:0] OPEN_RET_FULL  = 32'hFFFF_FFFF;
  localparam logic [31:0] MODE_WORD_CB   = 32'h0000_1000;
  localparam logic [31:0] MODE_WORD_MARK = 32'h0000_2000;
  localparam logic [4:0]  TABLE_ENTRIES_RST = 5'd16;

  typedef enum logic [2:0] {
    CMD_DELIVER = 3'd0,
    CMD_OPEN    = 3'd1,
    CMD_CLOSE   = 3'd2,
    CMD_TEST    = 3'd3,
    CMD_ENABLE  = 3'd4,
    CMD_DISABLE = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE     = 2'd0,
    ST_DISABLED = 2'd1,
    ST_ENABLED  = 2'd2,
    ST_READY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MD_NONE     = 2'd0,
    MD_CALLBACK = 2'd1,
    MD_MARK     = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINAL
  } fsm_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] event_class;
    logic [31:0] event_spec;
    logic [31:0] event_mode;
    logic [31:0] handler_address;
    logic [15:0] event_handle;
  } in_item_t;

  typedef struct packed {
    logic [31:0] return_value;
    logic        callback_valid;
    logic [31:0] callback_address;
    logic        handle_out_of_range;
    logic        last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic step_idx;
    logic do_mark;
    logic emit_cb;
    logic open_write;
    logic emit_final;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_deliver;
    logic is_open;
    logic scan_done;
    logic cur_free;
    logic cb_hit;
    logic mark_hit;
    logic slot_free;
  } dp_stat_t;

endpackage

### sv/ecbt_ctrl.sv
module ecbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ecbt_pkg::dp_stat_t stat,
  output ecbt_pkg::dp_cmd_t  cmd
);
  import ecbt_pkg::*;

  fsm_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.is_deliver) begin
          if (stat.scan_done) begin
            state_nxt = S_FINAL;
          end else if (stat.cb_hit) begin
            // hold the entry until the output slot takes the callback
            if (stat.slot_free) begin
              cmd.emit_cb  = 1'b1;
              cmd.step_idx = 1'b1;
            end
          end else begin
            cmd.do_mark  = stat.mark_hit;
            cmd.step_idx = 1'b1;
          end
        end else if (stat.is_open) begin
          if (stat.scan_done) begin
            state_nxt = S_FINAL;
          end else if (stat.cur_free) begin
            cmd.open_write = 1'b1;
            state_nxt      = S_FINAL;
          end else begin
            cmd.step_idx = 1'b1;
          end
        end else begin
          state_nxt = S_FINAL;
        end
      end
      S_FINAL: begin
        if (stat.slot_free) begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### sv/ecbt_dp.sv
module ecbt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata,
  input  ecbt_pkg::in_item_t  in_item,
  output ecbt_pkg::out_item_t out_item,
  output logic                out_valid,
  input  logic                out_ready,
  input  ecbt_pkg::dp_cmd_t   cmd,
  output ecbt_pkg::dp_stat_t  stat
);
  import ecbt_pkg::*;

  logic [4:0]       table_entries_r;
  in_item_t         item_r;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             found_r;
  out_item_t        out_r;
  logic             out_valid_r;

  status_t          status_r [MAX_ENTRIES];
  logic [31:0]      class_r  [MAX_ENTRIES];
  logic [31:0]      spec_r   [MAX_ENTRIES];
  mode_t            mode_r   [MAX_ENTRIES];
  logic [31:0]      handler_r[MAX_ENTRIES];

  logic [CNT_W-1:0] live_n;
  logic [IDX_W-1:0] cur;
  logic [IDX_W-1:0] hidx;
  logic             handle_oor;
  logic             match;
  mode_t            open_mode;
  out_item_t        final_res;
  cmd_t             item_cmd;

  always_comb begin
    if (table_entries_r == 5'd0) begin
      live_n = CNT_W'(1);
    end else if (32'(table_entries_r) > 32'(MAX_ENTRIES)) begin
      live_n = CNT_W'(MAX_ENTRIES);
    end else begin
      live_n = CNT_W'(table_entries_r);
    end
  end

  assign item_cmd   = cmd_t'(item_r.command);
  assign cur        = idx_r[IDX_W-1:0];
  assign hidx       = item_r.event_handle[IDX_W-1:0];
  assign handle_oor = 32'(item_r.event_handle) >= 32'(live_n);
  assign match      = (status_r[cur] == ST_ENABLED) &&
                      (class_r[cur] == item_r.event_class) &&
                      (spec_r[cur] == item_r.event_spec);

  always_comb begin
    if (item_r.event_mode == MODE_WORD_CB) begin
      open_mode = MD_CALLBACK;
    end else if (item_r.event_mode == MODE_WORD_MARK) begin
      open_mode = MD_MARK;
    end else begin
      open_mode = MD_NONE;
    end
  end

  assign stat.is_deliver = item_cmd == CMD_DELIVER;
  assign stat.is_open    = item_cmd == CMD_OPEN;
  assign stat.scan_done  = idx_r == live_n;
  assign stat.cur_free   = status_r[cur] == ST_FREE;
  assign stat.cb_hit     = match && (mode_r[cur] == MD_CALLBACK) && (handler_r[cur] != 32'd0);
  assign stat.mark_hit   = match && (mode_r[cur] == MD_MARK);
  assign stat.slot_free  = !out_valid_r || out_ready;

  // final result of the item
  always_comb begin
    final_res      = '0;
    final_res.last = 1'b1;
    case (item_cmd)
      CMD_DELIVER: begin
      end
      CMD_OPEN: begin
        final_res.return_value = found_r ? (OPEN_RET_BASE | 32'(idx_r)) : OPEN_RET_FULL;
      end
      CMD_CLOSE, CMD_ENABLE, CMD_DISABLE: begin
        final_res.handle_out_of_range = handle_oor;
        final_res.return_value        = handle_oor ? 32'd0 : 32'd1;
      end
      CMD_TEST: begin
        final_res.handle_out_of_range = handle_oor;
        final_res.return_value        = 32'((!handle_oor) && (status_r[hidx] == ST_READY));
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.load_item) begin
      idx_nxt = '0;
    end else if (cmd.step_idx) begin
      idx_nxt = idx_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_entries_r <= TABLE_ENTRIES_RST;
      out_valid_r     <= 1'b0;
      found_r         <= 1'b0;
      idx_r           <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        status_r[i] <= ST_FREE;
      end
    end else begin
      if (cfg_we) begin
        table_entries_r <= cfg_wdata;
      end
      idx_r <= idx_nxt;
      if (cmd.load_item) begin
        found_r <= 1'b0;
      end else if (cmd.open_write) begin
        found_r <= 1'b1;
      end
      if (cmd.emit_cb || cmd.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.do_mark) begin
        status_r[cur] <= ST_READY;
      end
      if (cmd.open_write) begin
        status_r[cur] <= ST_DISABLED;
      end
      if (cmd.emit_final && !handle_oor) begin
        case (item_cmd)
          CMD_CLOSE: begin
            status_r[hidx] <= ST_FREE;
          end
          CMD_TEST: begin
            if (status_r[hidx] == ST_READY) begin
              status_r[hidx] <= ST_ENABLED;
            end
          end
          CMD_ENABLE: begin
            if (status_r[hidx] != ST_FREE) begin
              status_r[hidx] <= ST_ENABLED;
            end
          end
          CMD_DISABLE: begin
            if (status_r[hidx] != ST_FREE) begin
              status_r[hidx] <= ST_DISABLED;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_item;
    end
    if (cmd.open_write) begin
      class_r[cur]   <= item_r.event_class;
      spec_r[cur]    <= item_r.event_spec;
      mode_r[cur]    <= open_mode;
      handler_r[cur] <= item_r.handler_address;
    end
    if (cmd.emit_cb) begin
      out_r <= '{return_value: 32'd0, callback_valid: 1'b1,
                 callback_address: handler_r[cur], handle_out_of_range: 1'b0,
                 last: 1'b0};
    end else if (cmd.emit_final) begin
      out_r <= final_res;
    end
  end

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

### sv/event_control_block_table.sv
// Event control block table.
// Input channel (in_valid/in_ready/in_item): one service command per item:
//   deliver, open, close, test, enable or disable.
// Result channel (out_valid/out_ready/out_item): one or more result items per
//   command; the final one carries last = 1 and the return word. Deliver gives
//   one callback result per matching callback entry (nonzero handler) first.
// Config (cfg_we/cfg_wdata): table_entries, taken at any edge with cfg_we high.
// Scan: the table is scanned one entry per cycle in a single scan loop,
//   except while a callback hit waits for the output register to free up.
//   close/test/enable/disable: no scan. open: the scan stops at the first
//   free entry, else after all n entries. deliver: all n entries are
//   scanned, n = effective entry count.
// One command at a time; the next is accepted on the cycle after the final
// result is loaded into the output register, even while it still waits.
// A stalled receiver holds the output register; the scan waits at the next
// callback hit and the final result waits for the register to free up.
// Reset (rst_n, synchronous): all entries free, table_entries = 16, no result.
module event_control_block_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ecbt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output ecbt_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [4:0]          cfg_wdata
);
  import ecbt_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: idle / scan / final
  ecbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // entry table, scan index and output register
  ecbt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
